/* rtl/sll_pkg.sv */
// shared types, token kinds, scan modes and keyword matching for the lexer
// used by all lexer modules; no dependencies
package sll_pkg;

    localparam int PosBitsDefault    = 16;
    localparam int KeywordMaxDefault = 6;

    localparam logic [5:0] K_DOT      = 6'd5;
    localparam logic [5:0] K_SLASH    = 6'd9;
    localparam logic [5:0] K_OPBASE   = 6'd11;
    localparam logic [5:0] K_IDENT    = 6'd19;
    localparam logic [5:0] K_STRING   = 6'd20;
    localparam logic [5:0] K_NUMBER   = 6'd21;
    localparam logic [5:0] K_ERR_CHAR = 6'd38;
    localparam logic [5:0] K_ERR_STR  = 6'd39;
    localparam logic [5:0] K_END      = 6'd40;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_OP      = 4'd1,
        M_SLASH   = 4'd2,
        M_COMMENT = 4'd3,
        M_IDENT   = 4'd4,
        M_INT     = 4'd5,
        M_DOT     = 4'd6,
        M_FRAC    = 4'd7,
        M_STRING  = 4'd8,
        M_DONE    = 4'd9
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
    } t_tok;

    typedef struct packed {
        logic [1:0] cnt;
        t_tok       t0;
        t_tok       t1;
    } t_emit;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == "_");
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        case (c)
            "(": return 6'd0;
            ")": return 6'd1;
            "{": return 6'd2;
            "}": return 6'd3;
            ",": return 6'd4;
            ".": return 6'd5;
            "-": return 6'd6;
            "+": return 6'd7;
            ";": return 6'd8;
            "/": return 6'd9;
            "*": return 6'd10;
            default: return K_ERR_CHAR;
        endcase
    endfunction

    // p holds the first six bytes, p[0] first; n is the identifier length
    function automatic logic [5:0] kw_kind(input logic [5:0][7:0] p, input logic [2:0] n);
        logic [47:0] w;
        w = {p[0], p[1], p[2], p[3], p[4], p[5]};
        case (n)
            3'd2: begin
                case (w[47:32])
                    "if": return 6'd28;
                    "or": return 6'd30;
                    default: return K_IDENT;
                endcase
            end
            3'd3: begin
                case (w[47:24])
                    "and": return 6'd22;
                    "for": return 6'd26;
                    "fun": return 6'd27;
                    "nil": return 6'd29;
                    "var": return 6'd36;
                    default: return K_IDENT;
                endcase
            end
            3'd4: begin
                case (w[47:16])
                    "else": return 6'd24;
                    "this": return 6'd34;
                    "true": return 6'd35;
                    default: return K_IDENT;
                endcase
            end
            3'd5: begin
                case (w[47:8])
                    "class": return 6'd23;
                    "false": return 6'd25;
                    "print": return 6'd31;
                    "super": return 6'd33;
                    "while": return 6'd37;
                    default: return K_IDENT;
                endcase
            end
            3'd6: begin
                case (w)
                    "return": return 6'd32;
                    default: return K_IDENT;
                endcase
            end
            default: return K_IDENT;
        endcase
    endfunction

endpackage

/* rtl/script_language_lexer_top.sv */
// lexer top level: input register, scanner core and token queue
// depends on sll_pkg, sll_core, sll_outq
// a byte is registered, then its tokens enter the queue when it has room and appear
// on the output straight from the queue; throughput one byte per cycle while the queue
// has room; tokens drain one per cycle when taken, so multi-token bytes can stall input
// reset: synchronous active low; scanner idle, position 0, line 1, queue empty
module script_language_lexer_top #(
    parameter int POS_BITS    = sll_pkg::PosBitsDefault,
    parameter int KEYWORD_MAX = sll_pkg::KeywordMaxDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // token_kind, start_pos, token_len, line_no, 2'b0 pad
    output logic        m_axis_tlast    // run_last
);
    logic       r_v;
    logic [7:0] r_c;
    logic       space, step;
    logic [1:0] cnt;
    sll_pkg::t_tok t0, t1, t2, tq;

    assign step = r_v && space;
    assign s_axis_tready = !r_v || space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= 1'b0;
        else if (s_axis_tready) r_v <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) r_c <= s_axis_tdata;
    end

    sll_core #(.POS_BITS(POS_BITS), .KEYWORD_MAX(KEYWORD_MAX)) u_core (
        .i_clk, .i_rst_n, .i_step(step), .i_char(r_c),
        .o_cnt(cnt), .o_tok0(t0), .o_tok1(t1), .o_tok2(t2)
    );

    sll_outq u_q (
        .i_clk, .i_rst_n, .i_push(step), .i_cnt(cnt),
        .i_tok0(t0), .i_tok1(t1), .i_tok2(t2),
        .o_space(space), .o_valid(m_axis_tvalid), .o_tok(tq), .o_last(m_axis_tlast),
        .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, tq.line, tq.len, tq.start, tq.kind};

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast)) else $error("output item changed while stalled");
    a_no_step_without_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> space) else $error("step without room");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> tq.kind <= sll_pkg::K_END) else $error("kind out of range");
endmodule

/* rtl/sll_core.sv */
// scanner state and per-byte token decision: up to three tokens per item
// depends on sll_pkg
module sll_core #(
    parameter int POS_BITS    = sll_pkg::PosBitsDefault,
    parameter int KEYWORD_MAX = sll_pkg::KeywordMaxDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic [7:0]     i_char,
    output logic [1:0]     o_cnt,
    output sll_pkg::t_tok  o_tok0,
    output sll_pkg::t_tok  o_tok1,
    output sll_pkg::t_tok  o_tok2
);
    localparam logic [POS_BITS-1:0] PosMax = {POS_BITS{1'b1}};
    localparam int KB = $clog2(KEYWORD_MAX);

    sll_pkg::t_mode r_mode, n_mode;
    logic [1:0]          r_op, n_op;
    logic [POS_BITS-1:0] r_pos, r_start, n_start;
    logic [15:0]         r_line, n_line;
    logic [KEYWORD_MAX-1:0][7:0] r_pfx;
    logic                pfx_we;
    logic [KB-1:0]       pfx_idx;

    logic [POS_BITS-1:0] diff, dp;
    logic [15:0] diff16, line_now;
    logic idle, adv;
    logic [5:0][7:0] p6;
    logic [2:0] klen;
    sll_pkg::t_tok tk[3];
    logic [1:0] cnt;

    function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] v);
        if (POS_BITS > 16 && (v >> 16) != '0) return 16'hFFFF;
        return 16'(v);
    endfunction

    assign diff   = r_pos - r_start;
    assign diff16 = sat16(diff);
    assign dp     = (r_pos > r_start) ? r_pos - 1'b1 : r_start;

    // klen of 7 stands for any identifier longer than six bytes
    always_comb begin
        for (int j = 0; j < 6; j++) p6[j] = (j < KEYWORD_MAX) ? r_pfx[j] : 8'd0;
        klen = (diff > POS_BITS'(6)) ? 3'd7 : 3'(diff);
    end

    always_comb begin
        n_mode = r_mode; n_op = r_op; n_start = r_start; n_line = r_line;
        idle = 1'b0; adv = 1'b1; cnt = 2'd0;
        pfx_we = 1'b0; pfx_idx = '0;
        for (int j = 0; j < 3; j++) tk[j] = '0;
        line_now = r_line;
        case (r_mode)
            sll_pkg::M_DONE: begin
                adv = 1'b0;
                if (i_char == 8'd0) begin
                    tk[0] = '{sll_pkg::K_END, 16'(r_pos), 16'd0, r_line}; cnt = 2'd1;
                end
            end
            sll_pkg::M_COMMENT: begin
                if (i_char == 8'h0A || i_char == 8'd0) begin n_mode = sll_pkg::M_IDLE; idle = 1'b1; end
            end
            sll_pkg::M_SLASH: begin
                if (i_char == "/") n_mode = sll_pkg::M_COMMENT;
                else begin
                    tk[0] = '{sll_pkg::K_SLASH, 16'(r_start), 16'd1, r_line}; cnt = 2'd1;
                    n_mode = sll_pkg::M_IDLE; idle = 1'b1;
                end
            end
            sll_pkg::M_OP: begin
                if (i_char == "=") begin
                    tk[0] = '{sll_pkg::K_OPBASE + {3'd0, r_op, 1'b1}, 16'(r_start), 16'd2, r_line};
                    cnt = 2'd1; n_mode = sll_pkg::M_IDLE;
                end else begin
                    tk[0] = '{sll_pkg::K_OPBASE + {3'd0, r_op, 1'b0}, 16'(r_start), 16'd1, r_line};
                    cnt = 2'd1; n_mode = sll_pkg::M_IDLE; idle = 1'b1;
                end
            end
            sll_pkg::M_IDENT: begin
                if (sll_pkg::is_alpha(i_char) || sll_pkg::is_digit(i_char)) begin
                    if (diff < POS_BITS'(KEYWORD_MAX)) begin pfx_we = 1'b1; pfx_idx = KB'(diff); end
                end else begin
                    tk[0] = '{sll_pkg::kw_kind(p6, klen), 16'(r_start), diff16, r_line};
                    cnt = 2'd1; n_mode = sll_pkg::M_IDLE; idle = 1'b1;
                end
            end
            sll_pkg::M_INT: begin
                if (i_char == ".") n_mode = sll_pkg::M_DOT;
                else if (!sll_pkg::is_digit(i_char)) begin
                    tk[0] = '{sll_pkg::K_NUMBER, 16'(r_start), diff16, r_line}; cnt = 2'd1;
                    n_mode = sll_pkg::M_IDLE; idle = 1'b1;
                end
            end
            sll_pkg::M_DOT: begin
                if (sll_pkg::is_digit(i_char)) n_mode = sll_pkg::M_FRAC;
                else begin
                    tk[0] = '{sll_pkg::K_NUMBER, 16'(r_start), sat16(dp - r_start), r_line};
                    tk[1] = '{sll_pkg::K_DOT, 16'(dp), 16'd1, r_line}; cnt = 2'd2;
                    n_mode = sll_pkg::M_IDLE; idle = 1'b1;
                end
            end
            sll_pkg::M_FRAC: begin
                if (!sll_pkg::is_digit(i_char)) begin
                    tk[0] = '{sll_pkg::K_NUMBER, 16'(r_start), diff16, r_line}; cnt = 2'd1;
                    n_mode = sll_pkg::M_IDLE; idle = 1'b1;
                end
            end
            sll_pkg::M_STRING: begin
                if (i_char == "\"") begin
                    tk[0] = '{sll_pkg::K_STRING, 16'(r_start),
                              sat16(diff + 1'b1) | {16{diff == PosMax}}, r_line};
                    cnt = 2'd1; n_mode = sll_pkg::M_IDLE;
                end else if (i_char == 8'd0) begin
                    tk[0] = '{sll_pkg::K_ERR_STR, 16'(r_start), diff16, r_line}; cnt = 2'd1;
                    n_mode = sll_pkg::M_IDLE; idle = 1'b1;
                end else if (i_char == 8'h0A && r_line != 16'hFFFF) begin
                    n_line = r_line + 16'd1;
                end
            end
            default: begin n_mode = sll_pkg::M_IDLE; idle = 1'b1; end
        endcase

        if (idle) begin
            if (i_char == 8'd0) begin
                tk[cnt] = '{sll_pkg::K_END, 16'(r_pos), 16'd0, line_now};
                cnt = cnt + 2'd1; n_mode = sll_pkg::M_DONE; adv = 1'b0;
            end else if (i_char == " " || i_char == 8'h0D || i_char == 8'h09) begin
                n_mode = sll_pkg::M_IDLE;
            end else if (i_char == 8'h0A) begin
                if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
            end else if (i_char == "/") begin
                n_start = r_pos; n_mode = sll_pkg::M_SLASH;
            end else if (sll_pkg::is_alpha(i_char)) begin
                n_start = r_pos; pfx_we = 1'b1; pfx_idx = '0; n_mode = sll_pkg::M_IDENT;
            end else if (sll_pkg::is_digit(i_char)) begin
                n_start = r_pos; n_mode = sll_pkg::M_INT;
            end else if (i_char == "\"") begin
                n_start = r_pos; n_mode = sll_pkg::M_STRING;
            end else if (i_char == "!" || i_char == "=" || i_char == ">" || i_char == "<") begin
                n_start = r_pos; n_mode = sll_pkg::M_OP;
                n_op = (i_char == "!") ? 2'd0 : (i_char == "=") ? 2'd1
                     : (i_char == ">") ? 2'd2 : 2'd3;
            end else begin
                tk[cnt] = '{sll_pkg::punct_kind(i_char), 16'(r_pos), 16'd1, line_now};
                cnt = cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sll_pkg::M_IDLE; r_op <= '0; r_pos <= '0; r_start <= '0; r_line <= 16'd1;
        end else if (i_step) begin
            r_mode <= n_mode; r_op <= n_op; r_start <= n_start; r_line <= n_line;
            if (adv && r_pos != PosMax) r_pos <= r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && pfx_we) r_pfx[pfx_idx] <= i_char;
    end

    assign o_cnt  = cnt;
    assign o_tok0 = tk[0];
    assign o_tok1 = tk[1];
    assign o_tok2 = tk[2];
endmodule

/* rtl/sll_outq.sv */
// token queue: takes up to three tokens per item, drains one per cycle when taken
// depends on sll_pkg
module sll_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [1:0]     i_cnt,
    input  sll_pkg::t_tok  i_tok0,
    input  sll_pkg::t_tok  i_tok1,
    input  sll_pkg::t_tok  i_tok2,
    output logic           o_space,
    output logic           o_valid,
    output sll_pkg::t_tok  o_tok,
    output logic           o_last,
    input  logic           i_ready
);
    localparam int Depth = 8;
    sll_pkg::t_tok r_q[Depth];
    logic          r_l[Depth];
    logic [2:0] r_rd, r_wr;
    logic [3:0] r_fill, n_fill;
    logic pop;

    assign o_valid = r_fill != 4'd0;
    assign pop     = o_valid && i_ready;
    assign o_tok   = r_q[r_rd];
    assign o_last  = r_l[r_rd];
    // room for three more even without a pop this cycle
    assign o_space = r_fill <= 4'd5;
    assign n_fill  = r_fill + (i_push ? {2'b0, i_cnt} : 4'd0) - {3'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_fill <= '0;
        end else begin
            if (pop) r_rd <= r_rd + 3'd1;
            if (i_push) r_wr <= r_wr + {1'b0, i_cnt};
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (i_cnt >= 2'd1) begin r_q[r_wr] <= i_tok0; r_l[r_wr] <= i_cnt == 2'd1; end
            if (i_cnt >= 2'd2) begin
                r_q[r_wr + 3'd1] <= i_tok1; r_l[r_wr + 3'd1] <= i_cnt == 2'd2;
            end
            if (i_cnt == 2'd3) begin r_q[r_wr + 3'd2] <= i_tok2; r_l[r_wr + 3'd2] <= 1'b1; end
        end
    end
endmodule
